// ===== rtl/icp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icp_pkg
// Shared types, codes and helpers for the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package icp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_MOD   = 8'h25;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        CODE_NONE = 3'd0,
        CODE_OPEN = 3'd1,
        CODE_ADD  = 3'd2,
        CODE_SUB  = 3'd3,
        CODE_MUL  = 3'd4,
        CODE_DIV  = 3'd5,
        CODE_MOD  = 3'd6
    } op_code_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ALNUM,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_OP
    } kind_t;

    typedef enum logic [1:0] {
        B_FETCH,
        B_BODY,
        B_FLUSH
    } back_state_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       expression_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       expression_end;
    } out_beat_t;

    typedef struct packed {
        kind_t      kind;
        op_code_t   code;
        logic [7:0] ch;
        logic       last;
    } cmd_t;

    function automatic logic [7:0] code_char(input op_code_t code);
        logic [7:0] c;
        case (code)
            CODE_OPEN: c = CH_OPEN;
            CODE_ADD:  c = CH_ADD;
            CODE_SUB:  c = CH_SUB;
            CODE_MUL:  c = CH_MUL;
            CODE_DIV:  c = CH_DIV;
            CODE_MOD:  c = CH_MOD;
            default:   c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] code_prec(input op_code_t code);
        logic [1:0] p;
        case (code)
            CODE_ADD, CODE_SUB:           p = 2'd1;
            CODE_MUL, CODE_DIV, CODE_MOD: p = 2'd2;
            default:                      p = 2'd0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/icp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icp_front
// Accepts input beats, classifies each character, and queues commands.
// ----------------------------------------------------------------------------
module icp_front
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  icp_pkg::in_beat_t    item,
    output logic                 cmd_valid,
    input  wire                  cmd_ready,
    output icp_pkg::cmd_t        cmd
);

    icp_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic          accept;
    logic          take;
    icp_pkg::cmd_t cls;

    always_comb
    begin
        cls.ch   = item.symbol;
        cls.last = item.expression_last;
        cls.code = icp_pkg::CODE_NONE;
        cls.kind = icp_pkg::KIND_NONE;
        if (item.symbol inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
        begin
            cls.kind = icp_pkg::KIND_ALNUM;
        end
        else
        begin
            case (item.symbol)
                icp_pkg::CH_OPEN:
                begin
                    cls.kind = icp_pkg::KIND_OPEN;
                    cls.code = icp_pkg::CODE_OPEN;
                end
                icp_pkg::CH_CLOSE: cls.kind = icp_pkg::KIND_CLOSE;
                icp_pkg::CH_ADD:
                begin
                    cls.kind = icp_pkg::KIND_OP;
                    cls.code = icp_pkg::CODE_ADD;
                end
                icp_pkg::CH_SUB:
                begin
                    cls.kind = icp_pkg::KIND_OP;
                    cls.code = icp_pkg::CODE_SUB;
                end
                icp_pkg::CH_MUL:
                begin
                    cls.kind = icp_pkg::KIND_OP;
                    cls.code = icp_pkg::CODE_MUL;
                end
                icp_pkg::CH_DIV:
                begin
                    cls.kind = icp_pkg::KIND_OP;
                    cls.code = icp_pkg::CODE_DIV;
                end
                icp_pkg::CH_MOD:
                begin
                    cls.kind = icp_pkg::KIND_OP;
                    cls.code = icp_pkg::CODE_MOD;
                end
                default: cls.kind = icp_pkg::KIND_NONE;
            endcase
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign accept    = push && !full;
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(accept) - 2'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("command queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/icp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icp_back
// Operator stack engine: runs commands, emits postfix beats into a result queue.
// ----------------------------------------------------------------------------
module icp_back
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    output logic                 cmd_ready,
    input  icp_pkg::cmd_t        cmd,
    output logic                 empty,
    input  wire                  pop,
    output icp_pkg::out_beat_t   result
);

    localparam int IW = icp_pkg::STACK_IDX_W;
    localparam int CW = icp_pkg::CNT_W;

    icp_pkg::op_code_t    stack_mem [icp_pkg::STACK_DEPTH];
    icp_pkg::back_state_t state_reg;
    icp_pkg::back_state_t state_next;
    icp_pkg::cmd_t        cmd_reg;
    icp_pkg::cmd_t        cmd_next;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    icp_pkg::op_code_t    top_reg;
    icp_pkg::op_code_t    top_next;

    logic                 mem_we;
    logic [CW-1:0]        wr_diff;
    logic [CW-1:0]        below_diff;
    icp_pkg::op_code_t    below;
    logic                 has_top;
    logic                 has_below;
    logic                 can_emit;
    logic                 emit;
    icp_pkg::out_beat_t   emit_beat;
    logic                 cont;
    logic                 pop_top;
    logic                 push_code;
    icp_pkg::op_code_t    push_val;

    icp_pkg::out_beat_t   oq_reg [2];
    logic                 oq_wr_reg;
    logic                 oq_rd_reg;
    logic [1:0]           oq_cnt_reg;
    logic                 oq_take;

    assign has_top    = (cnt_reg != '0);
    assign has_below  = (cnt_reg >= CW'(2));
    assign wr_diff    = cnt_reg - CW'(1);
    assign below_diff = cnt_reg - CW'(2);
    assign below      = stack_mem[below_diff[IW-1:0]];
    assign can_emit   = (oq_cnt_reg != 2'd2);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cmd_ready  = 1'b0;
        emit       = 1'b0;
        emit_beat  = '0;
        pop_top    = 1'b0;
        push_code  = 1'b0;
        push_val   = cmd_reg.code;
        cont       = 1'b0;
        case (state_reg)
            icp_pkg::B_FETCH:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = icp_pkg::B_BODY;
                end
            end
            icp_pkg::B_BODY:
            begin
                case (cmd_reg.kind)
                    icp_pkg::KIND_ALNUM:
                    begin
                        if (can_emit)
                        begin
                            emit               = 1'b1;
                            emit_beat.out_char = cmd_reg.ch;
                            emit_beat.run_last = !cmd_reg.last;
                            state_next = cmd_reg.last ? icp_pkg::B_FLUSH : icp_pkg::B_FETCH;
                        end
                    end
                    icp_pkg::KIND_OPEN:
                    begin
                        push_code  = 1'b1;
                        state_next = cmd_reg.last ? icp_pkg::B_FLUSH : icp_pkg::B_FETCH;
                    end
                    icp_pkg::KIND_CLOSE:
                    begin
                        cont = has_below && (below != icp_pkg::CODE_OPEN);
                        if (has_top && (top_reg != icp_pkg::CODE_OPEN))
                        begin
                            if (can_emit)
                            begin
                                emit               = 1'b1;
                                emit_beat.out_char = icp_pkg::code_char(top_reg);
                                emit_beat.run_last = !cmd_reg.last && !cont;
                                pop_top            = 1'b1;
                            end
                        end
                        else
                        begin
                            pop_top    = has_top;
                            state_next = cmd_reg.last ? icp_pkg::B_FLUSH : icp_pkg::B_FETCH;
                        end
                    end
                    icp_pkg::KIND_OP:
                    begin
                        cont = has_below &&
                            (icp_pkg::code_prec(below) >= icp_pkg::code_prec(cmd_reg.code));
                        if (has_top &&
                            (icp_pkg::code_prec(top_reg) >= icp_pkg::code_prec(cmd_reg.code)))
                        begin
                            if (can_emit)
                            begin
                                emit               = 1'b1;
                                emit_beat.out_char = icp_pkg::code_char(top_reg);
                                emit_beat.run_last = !cmd_reg.last && !cont;
                                pop_top            = 1'b1;
                            end
                        end
                        else
                        begin
                            push_code  = 1'b1;
                            state_next = cmd_reg.last ? icp_pkg::B_FLUSH : icp_pkg::B_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = cmd_reg.last ? icp_pkg::B_FLUSH : icp_pkg::B_FETCH;
                    end
                endcase
            end
            icp_pkg::B_FLUSH:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (has_top)
                    begin
                        emit_beat.out_char = icp_pkg::code_char(top_reg);
                        pop_top            = 1'b1;
                    end
                    else
                    begin
                        emit_beat.out_char       = icp_pkg::CH_NUL;
                        emit_beat.run_last       = 1'b1;
                        emit_beat.expression_end = 1'b1;
                        state_next               = icp_pkg::B_FETCH;
                    end
                end
            end
            default: state_next = icp_pkg::B_FETCH;
        endcase
    end

    // stack top lives in top_reg; entries below it live in stack_mem
    always_comb
    begin
        cnt_next = cnt_reg;
        top_next = top_reg;
        mem_we   = 1'b0;
        if (pop_top)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (has_below)
            begin
                top_next = below;
            end
        end
        else if (push_code && (cnt_reg < CW'(icp_pkg::STACK_DEPTH)))
        begin
            mem_we   = has_top;
            top_next = push_val;
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= icp_pkg::B_FETCH;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        top_reg <= top_next;
        if (mem_we)
        begin
            stack_mem[wr_diff[IW-1:0]] <= top_reg;
        end
    end

    assign empty   = (oq_cnt_reg == 2'd0);
    assign result  = oq_reg[oq_rd_reg];
    assign oq_take = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (emit)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_take)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            oq_cnt_reg <= oq_cnt_reg + 2'(emit) - 2'(oq_take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oq_reg[oq_wr_reg] <= emit_beat;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(icp_pkg::STACK_DEPTH))
        else $error("operator stack count beyond depth");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (oq_cnt_reg != 2'd2))
        else $error("result queue written while full");

    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_beat.expression_end) |-> (emit_beat.run_last && !has_top))
        else $error("terminator without empty stack or run_last");

    a_term_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_beat.expression_end) |=> (state_reg == icp_pkg::B_FETCH))
        else $error("terminator did not end the item");
`endif

endmodule
`default_nettype wire

// ===== rtl/infix_to_postfix_converter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard infix to postfix conversion, one character per input beat.
//
// Channel   Handshake        Payload
// input     push / full      item   : symbol[7:0], expression_last
// result    empty / pop      result : out_char[7:0], run_last, expression_end
//
// Each beat is fetched, then handled one result or stack pop at a time:
// a letter or digit is emitted, an operator first pops operators of equal or
// higher precedence, ')' pops operators and then drops the matching '('.
// A last beat then emits every stacked entry, then a terminator.
// Reset empties the stack and both queues; no clearing pass is needed.
// full rises with two commands queued; the engine stalls while both result
// slots are held.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  icp_pkg::in_beat_t    item,
    output logic                 empty,
    input  wire                  pop,
    output icp_pkg::out_beat_t   result
);

    logic          cmd_valid;
    logic          cmd_ready;
    icp_pkg::cmd_t cmd;

    icp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    icp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
`default_nettype wire
